[rtl/chct_pkg.sv]
// Shared types and constants for the charge hour countdown timer.
package chct_pkg;

  localparam int unsigned HOURS_W   = 3;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned RH_W      = 8;
  localparam int unsigned CFG_IDX_W = 8;

  typedef logic [HOURS_W-1:0] hours_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [RH_W-1:0]    rhours_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Hour count that wraps back to zero
  localparam hours_t HOURS_LIMIT = 3'd6;
  localparam hours_t HOURS_MAX   = 3'd5;

  // Register reset values
  localparam count_t TPH_RESET  = 16'd13786;
  localparam count_t SAVE_RESET = 16'd3446;
  localparam count_t COUNT_MAX  = 16'hFFFF;

  // Register indexes
  localparam cfg_idx_t REG_TICKS_PER_HOUR = 8'd0;
  localparam cfg_idx_t REG_SAVE_INTERVAL  = 8'd1;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RESTORE = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  // One result
  typedef struct packed {
    hours_t hours;
    logic   charge_on;
    logic   save_valid;
    hours_t save_hours;
    count_t save_count;
  } res_t;

endpackage

[rtl/charge_hour_countdown_timer.sv]
// Charge hour countdown timer: state update, result register and skid stage.
//
// Usage:
//   Requests enter on in_valid/in_ready: opcode (tick, press, restore, nop)
//   with restore_hours/restore_count used only by restore. Every request
//   yields exactly one result on out_valid/out_ready: hours left, LEDs lit,
//   charge enable and an optional checkpoint (save_valid, save_hours,
//   save_count; the latter two are zero without a checkpoint).
//   Registers ticks_per_hour (index 0) and save_interval (index 1) are
//   written on cfg_valid/cfg_ready; cfg_ready is always high. Write them
//   only while the block is idle.
//   Each accepted request's result is registered (result or skid register).
//   Throughput: one request per cycle while in_ready is high; the hour/count state
//   is updated in the accepting cycle by a single increment-and-compare pass.
//   When the receiver stalls, a second result is held in a skid register;
//   in_ready drops only while both result and skid registers are full.
//   Reset clears hours and count, loads the register defaults and empties
//   the output stages.
module charge_hour_countdown_timer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  chct_pkg::rhours_t restore_hours,
  input  chct_pkg::count_t  restore_count,
  output logic              out_valid,
  input  logic              out_ready,
  output chct_pkg::hours_t  hours_remaining,
  output chct_pkg::hours_t  leds_lit,
  output logic              charge_on,
  output logic              save_valid,
  output chct_pkg::hours_t  save_hours,
  output chct_pkg::count_t  save_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  chct_pkg::cfg_idx_t cfg_index,
  input  chct_pkg::count_t  cfg_data
);
  import chct_pkg::*;

  // Configuration, with the 2x and 3x interval products kept alongside
  count_t              ticks_per_hour;
  count_t              save_interval;
  logic [COUNT_W:0]    save_x2;
  logic [COUNT_W+1:0]  save_x3;

  // Timer state
  hours_t hours_left, hours_left_next;
  count_t tick_count, tick_count_next;

  // Output stages
  logic   res_valid, skid_valid;
  res_t   res, skid, res_new;
  logic   accept;
  logic   save_new;

  // Combinational helpers
  op_t    op;
  logic   running;
  count_t cnt_inc;
  logic   interval_hit;
  logic   raw_too_big;
  hours_t rest_hours;
  logic   rest_running;

  assign cfg_ready = 1'b1;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_hour <= TPH_RESET;
      save_interval  <= SAVE_RESET;
      save_x2        <= {SAVE_RESET, 1'b0};
      save_x3        <= {2'b00, SAVE_RESET} + {1'b0, SAVE_RESET, 1'b0};
    end else if (cfg_valid) begin
      if (cfg_index == REG_TICKS_PER_HOUR) begin
        ticks_per_hour <= cfg_data;
      end else if (cfg_index == REG_SAVE_INTERVAL) begin
        save_interval <= cfg_data;
        save_x2       <= {cfg_data, 1'b0};
        save_x3       <= {2'b00, cfg_data} + {1'b0, cfg_data, 1'b0};
      end
    end
  end

  // Next state and result for the incoming request
  always_comb begin
    op           = op_t'(opcode);
    running      = (hours_left != '0) && (hours_left <= HOURS_MAX);
    cnt_inc      = (tick_count == COUNT_MAX) ? tick_count : tick_count + 16'd1;
    interval_hit = (save_interval != '0) &&
                   ((cnt_inc == save_interval) ||
                    ({1'b0, cnt_inc} == save_x2) ||
                    ({2'b00, cnt_inc} == save_x3));
    raw_too_big  = restore_hours >= RH_W'(HOURS_LIMIT);
    rest_hours   = raw_too_big ? '0 : restore_hours[HOURS_W-1:0];
    rest_running = (rest_hours != '0);

    hours_left_next = hours_left;
    tick_count_next = tick_count;
    save_new        = 1'b0;

    unique case (op)
      OP_TICK: begin
        if (running) begin
          tick_count_next = cnt_inc;
          save_new        = interval_hit;
          if (cnt_inc >= ticks_per_hour) begin
            tick_count_next = '0;
            hours_left_next = hours_left - 3'd1;
            save_new        = 1'b1;
          end
        end
      end
      OP_PRESS: begin
        if (running) tick_count_next = '0;
        hours_left_next = (hours_left >= HOURS_MAX) ? '0 : hours_left + 3'd1;
        save_new        = 1'b1;
      end
      OP_RESTORE: begin
        hours_left_next = rest_hours;
        tick_count_next = (restore_count > ticks_per_hour) ? '0 : restore_count;
        save_new        = raw_too_big || rest_running;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase

    res_new.hours      = hours_left_next;
    res_new.charge_on  = (hours_left_next != '0);
    res_new.save_valid = save_new;
    res_new.save_hours = save_new ? hours_left_next : '0;
    res_new.save_count = save_new ? tick_count_next : '0;
  end

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      hours_left <= '0;
      tick_count <= '0;
    end else if (accept) begin
      hours_left <= hours_left_next;
      tick_count <= tick_count_next;
    end
  end

  // Result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_valid && !out_ready) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      res_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      res_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && !out_ready) begin
      if (accept) skid <= res_new;
    end else if (skid_valid) begin
      res <= skid;
    end else if (accept) begin
      res <= res_new;
    end
  end

  assign out_valid       = res_valid;
  assign hours_remaining = res.hours;
  assign leds_lit        = res.hours;
  assign charge_on       = res.charge_on;
  assign save_valid      = res.save_valid;
  assign save_hours      = res.save_hours;
  assign save_count      = res.save_count;

  // Checks
  a_skid_implies_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid full while result register empty");

  a_hours_range: assert property (@(posedge clk) disable iff (rst)
    hours_left <= HOURS_MAX)
    else $error("hours_left out of range");

  a_charge_matches_hours: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.charge_on == (res.hours != '0)))
    else $error("charge_on disagrees with hours");

  a_no_save_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.save_valid) |-> (res.save_count == '0 && res.save_hours == '0))
    else $error("checkpoint fields nonzero without checkpoint");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (accept && !skid_valid) |=> res_valid)
    else $error("accepted request produced no result");

endmodule
